>>> design/pipeline_stage_control_decoder_top_assert.svh
// Assertion macros for the pipeline stage control decoder.
// Included by the checker module; depends on nothing else.
`ifndef PIPELINE_STAGE_CONTROL_DECODER_TOP_ASSERT_SVH
`define PIPELINE_STAGE_CONTROL_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define PSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("control decoder assertion failed");

// Next-cycle implication.
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("control decoder assertion failed");

`endif

>>> design/psc_pkg.sv
// Shared types and codes for the pipeline stage control decoder.
// No dependencies; used by the channel interfaces and all modules.
package psc_pkg;

   typedef logic [6:0] opcode_type;
   typedef logic [2:0] funct3_type;
   typedef logic [6:0] funct7_type;

   // Opcodes
   localparam opcode_type OP_R      = 7'b0110011;
   localparam opcode_type OP_IMM    = 7'b0010011;
   localparam opcode_type OP_LOAD   = 7'b0000011;
   localparam opcode_type OP_JALR   = 7'b1100111;
   localparam opcode_type OP_STORE  = 7'b0100011;
   localparam opcode_type OP_BRANCH = 7'b1100011;
   localparam opcode_type OP_LUI    = 7'b0110111;
   localparam opcode_type OP_AUIPC  = 7'b0010111;
   localparam opcode_type OP_JAL    = 7'b1101111;

   localparam funct7_type F7_BASE   = 7'b0000000;
   localparam funct7_type F7_ALT    = 7'b0100000;
   localparam funct7_type F7_MULDIV = 7'b0000001;

   // Operand A selects
   localparam logic [2:0] SEL_A_PC_ZERO = 3'd0;
   localparam logic [2:0] SEL_A_RS1     = 3'd1;
   localparam logic [2:0] SEL_A_ZERO    = 3'd2;
   localparam logic [2:0] SEL_A_PC      = 3'd3;
   localparam logic [2:0] SEL_A_FWD_EX  = 3'd4;
   localparam logic [2:0] SEL_A_FWD_MEM = 3'd5;

   // Operand B selects
   localparam logic [3:0] SEL_B_NONE        = 4'd0;
   localparam logic [3:0] SEL_B_RS2         = 4'd1;
   localparam logic [3:0] SEL_B_IMM         = 4'd2;
   localparam logic [3:0] SEL_B_STORE_IMM   = 4'd3;
   localparam logic [3:0] SEL_B_UPPER_IMM   = 4'd4;
   localparam logic [3:0] SEL_B_FWD_EX      = 4'd5;
   localparam logic [3:0] SEL_B_FWD_EX_ST   = 4'd6;
   localparam logic [3:0] SEL_B_FWD_MEM     = 4'd7;
   localparam logic [3:0] SEL_B_FWD_MEM_ST  = 4'd8;

   // ALU operations
   localparam logic [4:0] ALU_NONE  = 5'd0;
   localparam logic [4:0] ALU_ADD   = 5'd1;
   localparam logic [4:0] ALU_SUB   = 5'd2;
   localparam logic [4:0] ALU_MUL   = 5'd3;
   localparam logic [4:0] ALU_DIV   = 5'd4;
   localparam logic [4:0] ALU_REM   = 5'd5;
   localparam logic [4:0] ALU_XOR   = 5'd6;
   localparam logic [4:0] ALU_OR    = 5'd7;
   localparam logic [4:0] ALU_AND   = 5'd8;
   localparam logic [4:0] ALU_SLL   = 5'd9;
   localparam logic [4:0] ALU_SRL   = 5'd10;
   localparam logic [4:0] ALU_SRA   = 5'd11;
   localparam logic [4:0] ALU_SLT   = 5'd12;
   localparam logic [4:0] ALU_BEQ   = 5'd13;
   localparam logic [4:0] ALU_BNE   = 5'd14;
   localparam logic [4:0] ALU_BLT   = 5'd15;
   localparam logic [4:0] ALU_BGE   = 5'd16;
   localparam logic [4:0] ALU_AUIPC = 5'd17;
   localparam logic [4:0] ALU_JALR  = 5'd18;

   // Memory data modes
   localparam logic [2:0] MEM_NONE       = 3'd0;
   localparam logic [2:0] MEM_LOAD_BASE  = 3'd1;
   localparam logic [2:0] MEM_STORE_BASE = 3'd4;
   localparam logic [2:0] MEM_STORE_WORD = 3'd6;

   // Result selects
   localparam logic [1:0] RES_NONE = 2'd0;
   localparam logic [1:0] RES_ALU  = 2'd1;
   localparam logic [1:0] RES_MEM  = 2'd2;
   localparam logic [1:0] RES_RA   = 2'd3;

   localparam funct3_type F3_WORD = 3'd2;

   // Upper limits of the select codes
   localparam logic [2:0] SEL_A_MAX = SEL_A_FWD_MEM;
   localparam logic [3:0] SEL_B_MAX = SEL_B_FWD_MEM_ST;
   localparam logic [4:0] ALU_MAX   = ALU_JALR;

   typedef struct packed {
      opcode_type decode_opcode;
      opcode_type execute_opcode;
      funct3_type execute_funct3;
      funct7_type execute_funct7;
      opcode_type memory_opcode;
      funct3_type memory_funct3;
      opcode_type writeback_opcode;
      logic       forward_a_from_execute;
      logic       forward_b_from_execute;
      logic       forward_a_from_memory;
      logic       forward_b_from_memory;
   } req_word_type;

   typedef struct packed {
      logic [2:0] operand_a_select;
      logic [3:0] operand_b_select;
      logic [4:0] alu_operation;
      logic       memory_address_select;
      logic [2:0] memory_data_mode;
      logic [1:0] result_select;
      logic       register_write_enable;
   } ctrl_type;

   function automatic logic known_opcode(input opcode_type op);
      logic known;
      unique case (op)
         OP_R, OP_IMM, OP_LOAD, OP_JALR, OP_STORE,
         OP_BRANCH, OP_LUI, OP_AUIPC, OP_JAL: known = 1'b1;
         default:                             known = 1'b0;
      endcase
      return known;
   endfunction

endpackage

>>> design/psc_channels.sv
// Valid/ready channel interfaces for the control decoder request and response.
// Depends on psc_pkg for the field types.
interface psc_req_if;
   logic                valid;
   logic                ready;
   psc_pkg::opcode_type decode_opcode;
   psc_pkg::opcode_type execute_opcode;
   psc_pkg::funct3_type execute_funct3;
   psc_pkg::funct7_type execute_funct7;
   psc_pkg::opcode_type memory_opcode;
   psc_pkg::funct3_type memory_funct3;
   psc_pkg::opcode_type writeback_opcode;
   logic                forward_a_from_execute;
   logic                forward_b_from_execute;
   logic                forward_a_from_memory;
   logic                forward_b_from_memory;

   modport source (
      output valid, decode_opcode, execute_opcode, execute_funct3, execute_funct7,
             memory_opcode, memory_funct3, writeback_opcode, forward_a_from_execute,
             forward_b_from_execute, forward_a_from_memory, forward_b_from_memory,
      input  ready
   );
   modport sink (
      input  valid, decode_opcode, execute_opcode, execute_funct3, execute_funct7,
             memory_opcode, memory_funct3, writeback_opcode, forward_a_from_execute,
             forward_b_from_execute, forward_a_from_memory, forward_b_from_memory,
      output ready
   );
endinterface

interface psc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] operand_a_select;
   logic [3:0] operand_b_select;
   logic [4:0] alu_operation;
   logic       memory_address_select;
   logic [2:0] memory_data_mode;
   logic [1:0] result_select;
   logic       register_write_enable;

   modport source (
      output valid, operand_a_select, operand_b_select, alu_operation,
             memory_address_select, memory_data_mode, result_select,
             register_write_enable,
      input  ready
   );
   modport sink (
      input  valid, operand_a_select, operand_b_select, alu_operation,
             memory_address_select, memory_data_mode, result_select,
             register_write_enable,
      output ready
   );
endinterface

>>> design/psc_decode.sv
// Combinational stage decode: next held control word from one input word.
// Depends on psc_pkg.
module psc_decode (
   input  psc_pkg::req_word_type word,
   input  psc_pkg::ctrl_type     held,
   input  logic                  forwarding_enable,
   output psc_pkg::ctrl_type     next_ctrl
);

   logic fa_ex;
   logic fb_ex;
   logic fa_mem;
   logic fb_mem;
   logic d_known;
   logic d_store;
   logic m_known;
   logic w_known;

   assign fa_ex   = forwarding_enable & word.forward_a_from_execute;
   assign fb_ex   = forwarding_enable & word.forward_b_from_execute;
   assign fa_mem  = forwarding_enable & word.forward_a_from_memory;
   assign fb_mem  = forwarding_enable & word.forward_b_from_memory;
   assign d_known = psc_pkg::known_opcode(word.decode_opcode);
   assign d_store = (word.decode_opcode == psc_pkg::OP_STORE);
   assign m_known = psc_pkg::known_opcode(word.memory_opcode);
   assign w_known = psc_pkg::known_opcode(word.writeback_opcode);

   always_comb begin
      // Operand selects (decode stage)
      next_ctrl.operand_a_select = held.operand_a_select;
      next_ctrl.operand_b_select = held.operand_b_select;
      priority if (fa_ex) begin
         next_ctrl.operand_a_select = psc_pkg::SEL_A_FWD_EX;
      end else if (fa_mem) begin
         next_ctrl.operand_a_select = psc_pkg::SEL_A_FWD_MEM;
      end else if (d_known) begin
         unique case (word.decode_opcode)
            psc_pkg::OP_LUI:   next_ctrl.operand_a_select = psc_pkg::SEL_A_ZERO;
            psc_pkg::OP_AUIPC: next_ctrl.operand_a_select = psc_pkg::SEL_A_PC;
            psc_pkg::OP_JAL:   next_ctrl.operand_a_select = psc_pkg::SEL_A_PC_ZERO;
            default:           next_ctrl.operand_a_select = psc_pkg::SEL_A_RS1;
         endcase
      end else begin
         next_ctrl.operand_a_select = held.operand_a_select;
      end
      // An unknown opcode without A forwarding leaves both selects alone
      if (fa_ex || fa_mem || d_known) begin
         priority if (fb_ex) begin
            next_ctrl.operand_b_select = d_store ? psc_pkg::SEL_B_FWD_EX_ST
                                                 : psc_pkg::SEL_B_FWD_EX;
         end else if (fb_mem) begin
            next_ctrl.operand_b_select = d_store ? psc_pkg::SEL_B_FWD_MEM_ST
                                                 : psc_pkg::SEL_B_FWD_MEM;
         end else begin
            unique case (word.decode_opcode)
               psc_pkg::OP_R, psc_pkg::OP_BRANCH:
                  next_ctrl.operand_b_select = psc_pkg::SEL_B_RS2;
               psc_pkg::OP_IMM, psc_pkg::OP_LOAD, psc_pkg::OP_JALR, psc_pkg::OP_AUIPC:
                  next_ctrl.operand_b_select = psc_pkg::SEL_B_IMM;
               psc_pkg::OP_STORE: next_ctrl.operand_b_select = psc_pkg::SEL_B_STORE_IMM;
               psc_pkg::OP_LUI:   next_ctrl.operand_b_select = psc_pkg::SEL_B_UPPER_IMM;
               psc_pkg::OP_JAL:   next_ctrl.operand_b_select = psc_pkg::SEL_B_NONE;
               default:           next_ctrl.operand_b_select = held.operand_b_select;
            endcase
         end
      end

      // ALU operation (execute stage); unknown combinations hold
      next_ctrl.alu_operation = held.alu_operation;
      unique case (word.execute_opcode)
         psc_pkg::OP_R: begin
            unique case (word.execute_funct3)
               3'd0: begin
                  priority if (word.execute_funct7 == psc_pkg::F7_BASE)
                     next_ctrl.alu_operation = psc_pkg::ALU_ADD;
                  else if (word.execute_funct7 == psc_pkg::F7_ALT)
                     next_ctrl.alu_operation = psc_pkg::ALU_SUB;
                  else if (word.execute_funct7 == psc_pkg::F7_MULDIV)
                     next_ctrl.alu_operation = psc_pkg::ALU_MUL;
                  else
                     next_ctrl.alu_operation = held.alu_operation;
               end
               3'd1: next_ctrl.alu_operation = psc_pkg::ALU_SLL;
               3'd2: next_ctrl.alu_operation = psc_pkg::ALU_SLT;
               3'd4: begin
                  priority if (word.execute_funct7 == psc_pkg::F7_MULDIV)
                     next_ctrl.alu_operation = psc_pkg::ALU_DIV;
                  else if (word.execute_funct7 == psc_pkg::F7_BASE)
                     next_ctrl.alu_operation = psc_pkg::ALU_XOR;
                  else
                     next_ctrl.alu_operation = held.alu_operation;
               end
               3'd5: begin
                  priority if (word.execute_funct7 == psc_pkg::F7_ALT)
                     next_ctrl.alu_operation = psc_pkg::ALU_SRA;
                  else if (word.execute_funct7 == psc_pkg::F7_BASE)
                     next_ctrl.alu_operation = psc_pkg::ALU_SRL;
                  else
                     next_ctrl.alu_operation = held.alu_operation;
               end
               3'd6: begin
                  priority if (word.execute_funct7 == psc_pkg::F7_MULDIV)
                     next_ctrl.alu_operation = psc_pkg::ALU_REM;
                  else if (word.execute_funct7 == psc_pkg::F7_BASE)
                     next_ctrl.alu_operation = psc_pkg::ALU_OR;
                  else
                     next_ctrl.alu_operation = held.alu_operation;
               end
               3'd7:    next_ctrl.alu_operation = psc_pkg::ALU_AND;
               default: next_ctrl.alu_operation = held.alu_operation;
            endcase
         end
         psc_pkg::OP_IMM: begin
            unique case (word.execute_funct3)
               3'd0:    next_ctrl.alu_operation = psc_pkg::ALU_ADD;
               3'd4:    next_ctrl.alu_operation = psc_pkg::ALU_XOR;
               3'd6:    next_ctrl.alu_operation = psc_pkg::ALU_OR;
               3'd7:    next_ctrl.alu_operation = psc_pkg::ALU_AND;
               default: next_ctrl.alu_operation = held.alu_operation;
            endcase
         end
         psc_pkg::OP_LOAD, psc_pkg::OP_STORE: next_ctrl.alu_operation = psc_pkg::ALU_ADD;
         psc_pkg::OP_JALR: next_ctrl.alu_operation = psc_pkg::ALU_JALR;
         psc_pkg::OP_BRANCH: begin
            unique case (word.execute_funct3)
               3'd0:    next_ctrl.alu_operation = psc_pkg::ALU_BEQ;
               3'd1:    next_ctrl.alu_operation = psc_pkg::ALU_BNE;
               3'd4:    next_ctrl.alu_operation = psc_pkg::ALU_BLT;
               3'd5:    next_ctrl.alu_operation = psc_pkg::ALU_BGE;
               default: next_ctrl.alu_operation = held.alu_operation;
            endcase
         end
         psc_pkg::OP_LUI:   next_ctrl.alu_operation = psc_pkg::ALU_SLL;
         psc_pkg::OP_AUIPC: next_ctrl.alu_operation = psc_pkg::ALU_AUIPC;
         psc_pkg::OP_JAL:   next_ctrl.alu_operation = psc_pkg::ALU_NONE;
         default:           next_ctrl.alu_operation = held.alu_operation;
      endcase

      // Memory stage and writeback
      next_ctrl.memory_address_select = held.memory_address_select;
      next_ctrl.memory_data_mode      = held.memory_data_mode;
      next_ctrl.result_select         = held.result_select;
      next_ctrl.register_write_enable = held.register_write_enable;
      if (m_known) begin
         next_ctrl.memory_address_select = (word.memory_opcode == psc_pkg::OP_LOAD) ||
                                           (word.memory_opcode == psc_pkg::OP_STORE);
         unique case (word.memory_opcode)
            psc_pkg::OP_LOAD: begin
               if (word.memory_funct3 <= psc_pkg::F3_WORD)
                  next_ctrl.memory_data_mode = psc_pkg::MEM_LOAD_BASE + word.memory_funct3;
               next_ctrl.result_select = psc_pkg::RES_MEM;
            end
            psc_pkg::OP_STORE: begin
               if (word.memory_funct3 <= psc_pkg::F3_WORD)
                  next_ctrl.memory_data_mode = psc_pkg::MEM_STORE_BASE + word.memory_funct3;
               next_ctrl.result_select = psc_pkg::RES_NONE;
            end
            psc_pkg::OP_JALR, psc_pkg::OP_JAL: begin
               next_ctrl.memory_data_mode = psc_pkg::MEM_NONE;
               next_ctrl.result_select    = psc_pkg::RES_RA;
            end
            psc_pkg::OP_BRANCH: begin
               next_ctrl.memory_data_mode = psc_pkg::MEM_NONE;
               next_ctrl.result_select    = psc_pkg::RES_NONE;
            end
            default: begin
               next_ctrl.memory_data_mode = psc_pkg::MEM_NONE;
               next_ctrl.result_select    = psc_pkg::RES_ALU;
            end
         endcase
      end
      if (w_known) begin
         next_ctrl.register_write_enable =
            !((word.writeback_opcode == psc_pkg::OP_STORE) ||
              (word.writeback_opcode == psc_pkg::OP_BRANCH));
      end
   end

endmodule

>>> design/pipeline_stage_control_decoder_top.sv
// Top level of the pipeline stage control decoder: input register, held
// control word (also the response register) and the decode logic between them.
// Depends on psc_pkg, psc_channels and psc_decode.
//
//   channel   direction  handshake       carries
//   req_chan  in         valid/ready     stage opcodes, funct fields, forwarding verdicts
//   rsp_chan  out        valid/ready     held control word
//   csr_*     in         write enable    forwarding_enable
//
// One word per clock while rsp_chan is not stalled; a word taken into the input
// register is decoded into the held control register, which drives rsp_chan.
// Synchronous reset clears the held control word to zero and sets forwarding on.
// A stalled response holds its word; the input register still takes one more
// word, then req ready drops until the response moves.
module pipeline_stage_control_decoder_top (
   input  logic           clock,
   input  logic           reset,
   psc_req_if.sink        req_chan,
   psc_rsp_if.source      rsp_chan,
   input  logic           csr_write_enable,
   input  logic           csr_write_data
);

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   psc_pkg::req_word_type s1_word_ff;
   psc_pkg::req_word_type req_word;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   psc_pkg::ctrl_type     held_ff;
   psc_pkg::ctrl_type     held_in;
   psc_pkg::ctrl_type     decoded;
   logic                  forwarding_enable_ff;
   logic                  forwarding_enable_in;
   logic                  advance;
   logic                  take;

   assign req_word = '{
      decode_opcode:          req_chan.decode_opcode,
      execute_opcode:         req_chan.execute_opcode,
      execute_funct3:         req_chan.execute_funct3,
      execute_funct7:         req_chan.execute_funct7,
      memory_opcode:          req_chan.memory_opcode,
      memory_funct3:          req_chan.memory_funct3,
      writeback_opcode:       req_chan.writeback_opcode,
      forward_a_from_execute: req_chan.forward_a_from_execute,
      forward_b_from_execute: req_chan.forward_b_from_execute,
      forward_a_from_memory:  req_chan.forward_a_from_memory,
      forward_b_from_memory:  req_chan.forward_b_from_memory
   };

   // Move the input word into the held register when the response slot frees
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   assign s1_valid_in          = take || (s1_valid_ff && !advance);
   assign out_valid_in         = advance || (out_valid_ff && !rsp_chan.ready);
   assign held_in              = advance ? decoded : held_ff;
   assign forwarding_enable_in = csr_write_enable ? csr_write_data : forwarding_enable_ff;

   psc_decode u_decode (
      .word              (s1_word_ff),
      .held              (held_ff),
      .forwarding_enable (forwarding_enable_ff),
      .next_ctrl         (decoded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         held_ff              <= '0;
         forwarding_enable_ff <= 1'b1;
      end else begin
         s1_valid_ff          <= s1_valid_in;
         out_valid_ff         <= out_valid_in;
         held_ff              <= held_in;
         forwarding_enable_ff <= forwarding_enable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_word_ff <= req_word;
      end
   end

   assign rsp_chan.valid                 = out_valid_ff;
   assign rsp_chan.operand_a_select      = held_ff.operand_a_select;
   assign rsp_chan.operand_b_select      = held_ff.operand_b_select;
   assign rsp_chan.alu_operation         = held_ff.alu_operation;
   assign rsp_chan.memory_address_select = held_ff.memory_address_select;
   assign rsp_chan.memory_data_mode      = held_ff.memory_data_mode;
   assign rsp_chan.result_select         = held_ff.result_select;
   assign rsp_chan.register_write_enable = held_ff.register_write_enable;

endmodule

>>> design/psc_checker.sv
// Port-level checks for the pipeline stage control decoder, bound to the top.
// Depends on psc_pkg and pipeline_stage_control_decoder_top_assert.svh.
`include "pipeline_stage_control_decoder_top_assert.svh"

module psc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] operand_a_select,
   input logic [3:0] operand_b_select,
   input logic [4:0] alu_operation,
   input logic       memory_address_select,
   input logic [2:0] memory_data_mode,
   input logic [1:0] result_select
);

   logic        codes_in_range;
   logic [13:0] shown_ctrl;

   assign codes_in_range = (operand_a_select <= psc_pkg::SEL_A_MAX) &&
                           (operand_b_select <= psc_pkg::SEL_B_MAX) &&
                           (alu_operation <= psc_pkg::ALU_MAX) &&
                           (memory_data_mode <= psc_pkg::MEM_STORE_WORD);
   assign shown_ctrl     = {operand_a_select, operand_b_select, alu_operation, result_select};

   // A draining response never backs up the request side
   `PSC_ASSERT_NOW(a_ready_follows_drain, clock, reset, rsp_ready, req_ready)

   // Only codes the decoder can produce
   `PSC_ASSERT_NOW(a_codes_in_range, clock, reset, rsp_valid, codes_in_range)

   // Memory data result only comes with a memory access
   `PSC_ASSERT_NOW(a_load_result_addr, clock, reset, rsp_valid && (result_select == psc_pkg::RES_MEM), memory_address_select)

   // Hold the word while stalled
   `PSC_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(shown_ctrl))

endmodule

bind pipeline_stage_control_decoder_top psc_checker u_psc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_ready             (req_chan.ready),
   .rsp_valid             (rsp_chan.valid),
   .rsp_ready             (rsp_chan.ready),
   .operand_a_select      (rsp_chan.operand_a_select),
   .operand_b_select      (rsp_chan.operand_b_select),
   .alu_operation         (rsp_chan.alu_operation),
   .memory_address_select (rsp_chan.memory_address_select),
   .memory_data_mode      (rsp_chan.memory_data_mode),
   .result_select         (rsp_chan.result_select)
);
